// ----- design/pbpa_pkg.sv -----
// Shared types and constants for the points-annotation message parser.
package pbpa_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam logic [63:0] DEFAULT_THICKNESS_RESET = 64'h4000_0000_0000_0000;
   localparam int RSP_DEPTH = 4;
   localparam int PTR_BITS = $clog2(RSP_DEPTH);

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_ANNOT = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_TAG   = 2'd0;
   localparam logic [1:0] ERR_ALEN  = 2'd1;
   localparam logic [1:0] ERR_ANNOT = 2'd2;
   localparam logic [1:0] ERR_SKIP  = 2'd3;

   localparam logic [1:0] NEST_TOP   = 2'd0;
   localparam logic [1:0] NEST_ANNOT = 2'd1;
   localparam logic [1:0] NEST_POINT = 2'd2;

   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_FIX64  = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_FIX32  = 3'd5;

   localparam logic [0:0] CSR_DEFAULT_THICKNESS = 1'b0;

   typedef enum logic [10:0] {
      PH_TAG    = 11'b000_0000_0001,
      PH_ALEN   = 11'b000_0000_0010,
      PH_PLEN   = 11'b000_0000_0100,
      PH_TOPO   = 11'b000_0000_1000,
      PH_SKIPV  = 11'b000_0001_0000,
      PH_SLEN   = 11'b000_0010_0000,
      PH_SBODY  = 11'b000_0100_0000,
      PH_FX     = 11'b000_1000_0000,
      PH_FY     = 11'b001_0000_0000,
      PH_FTHICK = 11'b010_0000_0000,
      PH_FSKIP  = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [63:0] x_bits;
      logic [63:0] y_bits;
      logic [1:0]  topology;
      logic [63:0] thickness_bits;
      logic [15:0] item_count;
      logic [1:0]  error_code;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      rsp_type [2:0] slot;
      logic [1:0]    count;
   } emit_type;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [63:0] x, logic [63:0] y,
                                        logic [1:0] topo, logic [63:0] thick,
                                        logic [15:0] cnt, logic [1:0] code);
      rsp_type r;
      r.event_kind     = kind;
      r.x_bits         = x;
      r.y_bits         = y;
      r.topology       = topo;
      r.thickness_bits = thick;
      r.item_count     = cnt;
      r.error_code     = code;
      r.run_last       = 1'b0;
      return r;
   endfunction

endpackage

// ----- design/pbpa_core.sv -----
// Parser state and per-byte decode producing up to three events per request.
module pbpa_core #(
   parameter int LENGTH_BITS = pbpa_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pbpa_pkg::req_type req,
   input  logic [63:0]       default_thickness,
   output pbpa_pkg::emit_type emit
);

   pbpa_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  nest_ff, nest_in;
   logic [63:0] accum_ff, accum_in;
   logic [3:0]  shift_ff, shift_in;
   logic [3:0]  fixed_ff, fixed_in;
   logic [LENGTH_BITS-1:0] al_ff, al_in, pl_ff, pl_in, sl_ff, sl_in;
   logic [63:0] px_ff, px_in, py_ff, py_in, thick_ff, thick_in;
   logic [1:0]  topo_ff, topo_in;
   logic [15:0] pcnt_ff, pcnt_in, acnt_ff, acnt_in;
   logic        failed_ff, failed_in;

   always_comb begin
      logic [7:0]  b;
      logic [63:0] v;
      logic [6:0]  sh7;
      logic [2:0]  bidx;
      logic [2:0]  w;
      logic [60:0] f;
      logic        done, toolong, v_big, err_v, boundary;
      logic [1:0]  err_c, n;
      logic [LENGTH_BITS-1:0] v_low, parent;
      b = req.data_byte;
      phase_in = phase_ff; nest_in = nest_ff; accum_in = accum_ff; shift_in = shift_ff;
      fixed_in = fixed_ff; al_in = al_ff; pl_in = pl_ff; sl_in = sl_ff;
      px_in = px_ff; py_in = py_ff; thick_in = thick_ff; topo_in = topo_ff;
      pcnt_in = pcnt_ff; acnt_in = acnt_ff; failed_in = failed_ff;
      emit = '0;
      n = 2'd0;
      err_v = 1'b0;
      err_c = pbpa_pkg::ERR_TAG;
      sh7 = 7'(shift_ff) * 7'd7;
      if (shift_ff < 4'd9) begin
         v = accum_ff | ({57'b0, b[6:0]} << sh7);
      end else begin
         v = accum_ff | {b[0], 63'b0};
      end
      done = !b[7];
      toolong = b[7] && (shift_ff >= 4'd9);
      v_big = |(v >> LENGTH_BITS);
      v_low = v[LENGTH_BITS-1:0];
      f = v[63:3];
      w = v[2:0];
      parent = (nest_ff == pbpa_pkg::NEST_POINT) ? pl_ff : al_ff;
      bidx = '0;
      boundary = 1'b0;

      if (!failed_ff) begin
         if (nest_ff != pbpa_pkg::NEST_TOP && al_ff != '0) al_in = al_ff - 1'b1;
         if (nest_ff == pbpa_pkg::NEST_POINT && pl_ff != '0) pl_in = pl_ff - 1'b1;
         parent = (nest_ff == pbpa_pkg::NEST_POINT) ? pl_in : al_in;

         unique case (phase_ff)
            pbpa_pkg::PH_TAG, pbpa_pkg::PH_ALEN, pbpa_pkg::PH_PLEN, pbpa_pkg::PH_TOPO,
            pbpa_pkg::PH_SKIPV, pbpa_pkg::PH_SLEN: begin
               if (toolong) begin
                  err_v = 1'b1;
                  if (nest_ff != pbpa_pkg::NEST_TOP) err_c = pbpa_pkg::ERR_ANNOT;
                  else if (phase_ff == pbpa_pkg::PH_TAG) err_c = pbpa_pkg::ERR_TAG;
                  else if (phase_ff == pbpa_pkg::PH_ALEN) err_c = pbpa_pkg::ERR_ALEN;
                  else err_c = pbpa_pkg::ERR_SKIP;
               end else if (!done) begin
                  accum_in = v;
                  shift_in = shift_ff + 4'd1;
               end else begin
                  accum_in = '0;
                  shift_in = '0;
                  unique case (phase_ff)
                     pbpa_pkg::PH_TAG: begin
                        // Known fields first; anything else is skipped by wire kind.
                        if (nest_ff == pbpa_pkg::NEST_TOP && f == 61'd2
                            && w == pbpa_pkg::WIRE_LEN) begin
                           phase_in = pbpa_pkg::PH_ALEN;
                        end else if (nest_ff == pbpa_pkg::NEST_ANNOT && f == 61'd2
                                     && w == pbpa_pkg::WIRE_VARINT) begin
                           phase_in = pbpa_pkg::PH_TOPO;
                        end else if (nest_ff == pbpa_pkg::NEST_ANNOT && f == 61'd3
                                     && w == pbpa_pkg::WIRE_LEN) begin
                           phase_in = pbpa_pkg::PH_PLEN;
                        end else if (nest_ff == pbpa_pkg::NEST_ANNOT && f == 61'd7
                                     && w == pbpa_pkg::WIRE_FIX64) begin
                           phase_in = pbpa_pkg::PH_FTHICK; fixed_in = 4'd8;
                        end else if (nest_ff == pbpa_pkg::NEST_POINT && f == 61'd1
                                     && w == pbpa_pkg::WIRE_FIX64) begin
                           phase_in = pbpa_pkg::PH_FX; fixed_in = 4'd8;
                        end else if (nest_ff == pbpa_pkg::NEST_POINT && f == 61'd2
                                     && w == pbpa_pkg::WIRE_FIX64) begin
                           phase_in = pbpa_pkg::PH_FY; fixed_in = 4'd8;
                        end else if (w == pbpa_pkg::WIRE_VARINT) begin
                           phase_in = pbpa_pkg::PH_SKIPV;
                        end else if (w == pbpa_pkg::WIRE_FIX64) begin
                           phase_in = pbpa_pkg::PH_FSKIP; fixed_in = 4'd8;
                        end else if (w == pbpa_pkg::WIRE_LEN) begin
                           phase_in = pbpa_pkg::PH_SLEN;
                        end else if (w == pbpa_pkg::WIRE_FIX32) begin
                           phase_in = pbpa_pkg::PH_FSKIP; fixed_in = 4'd4;
                        end else begin
                           err_v = 1'b1;
                           err_c = (nest_ff != pbpa_pkg::NEST_TOP) ? pbpa_pkg::ERR_ANNOT
                                                                   : pbpa_pkg::ERR_SKIP;
                        end
                     end
                     pbpa_pkg::PH_ALEN: begin
                        if (v_big) begin
                           err_v = 1'b1; err_c = pbpa_pkg::ERR_ANNOT;
                        end else begin
                           nest_in = pbpa_pkg::NEST_ANNOT; al_in = v_low;
                           phase_in = pbpa_pkg::PH_TAG; topo_in = '0;
                           thick_in = default_thickness; pcnt_in = '0;
                        end
                     end
                     pbpa_pkg::PH_PLEN: begin
                        if (v_big || v_low > al_in) begin
                           err_v = 1'b1; err_c = pbpa_pkg::ERR_ANNOT;
                        end else begin
                           nest_in = pbpa_pkg::NEST_POINT; pl_in = v_low;
                           phase_in = pbpa_pkg::PH_TAG; px_in = '0; py_in = '0;
                        end
                     end
                     pbpa_pkg::PH_TOPO: begin
                        if (v == 64'd2) topo_in = 2'd1;
                        else if (v == 64'd3) topo_in = 2'd2;
                        else if (v == 64'd4) topo_in = 2'd3;
                        else topo_in = 2'd0;
                        phase_in = pbpa_pkg::PH_TAG;
                     end
                     pbpa_pkg::PH_SKIPV: begin
                        phase_in = pbpa_pkg::PH_TAG;
                     end
                     default: begin
                        if (v_big) begin
                           err_v = 1'b1;
                           err_c = (nest_ff != pbpa_pkg::NEST_TOP) ? pbpa_pkg::ERR_ANNOT
                                                                   : pbpa_pkg::ERR_SKIP;
                        end else if (nest_ff != pbpa_pkg::NEST_TOP && v_low > parent) begin
                           err_v = 1'b1; err_c = pbpa_pkg::ERR_ANNOT;
                        end else if (v_low == '0) begin
                           phase_in = pbpa_pkg::PH_TAG;
                        end else begin
                           sl_in = v_low; phase_in = pbpa_pkg::PH_SBODY;
                        end
                     end
                  endcase
               end
            end
            pbpa_pkg::PH_SBODY: begin
               if (sl_ff != '0) sl_in = sl_ff - 1'b1;
               if (sl_in == '0) phase_in = pbpa_pkg::PH_TAG;
            end
            default: begin
               fixed_in = (fixed_ff == 4'd0 || fixed_ff > 4'd8) ? 4'd1 : fixed_ff;
               bidx = 3'(4'd8 - fixed_in);
               accum_in = accum_ff | ({56'b0, b} << {bidx, 3'b0});
               fixed_in = fixed_in - 4'd1;
               if (fixed_in == 4'd0) begin
                  if (phase_ff == pbpa_pkg::PH_FX) px_in = accum_in;
                  else if (phase_ff == pbpa_pkg::PH_FY) py_in = accum_in;
                  else if (phase_ff == pbpa_pkg::PH_FTHICK) thick_in = accum_in;
                  accum_in = '0;
                  phase_in = pbpa_pkg::PH_TAG;
               end
            end
         endcase

         boundary = (phase_in == pbpa_pkg::PH_TAG) && (shift_in == 4'd0);
         if (!err_v && nest_in == pbpa_pkg::NEST_POINT && pl_in == '0) begin
            if (!boundary) begin
               err_v = 1'b1; err_c = pbpa_pkg::ERR_ANNOT;
            end else begin
               emit.slot[n] = pbpa_pkg::make_rsp(pbpa_pkg::KIND_POINT, px_in, py_in,
                                                 '0, '0, '0, '0);
               n = n + 2'd1;
               if (pcnt_in != 16'hFFFF) pcnt_in = pcnt_in + 16'd1;
               nest_in = pbpa_pkg::NEST_ANNOT;
            end
         end
         if (!err_v && nest_in == pbpa_pkg::NEST_ANNOT && al_in == '0) begin
            if (!boundary) begin
               err_v = 1'b1; err_c = pbpa_pkg::ERR_ANNOT;
            end else begin
               emit.slot[n] = pbpa_pkg::make_rsp(pbpa_pkg::KIND_ANNOT, '0, '0, topo_in,
                                                 thick_in, pcnt_in, '0);
               n = n + 2'd1;
               if (acnt_in != 16'hFFFF) acnt_in = acnt_in + 16'd1;
               nest_in = pbpa_pkg::NEST_TOP;
            end
         end
         if (!err_v && req.last_byte) begin
            if (nest_in == pbpa_pkg::NEST_TOP && boundary) begin
               emit.slot[n] = pbpa_pkg::make_rsp(pbpa_pkg::KIND_DONE, '0, '0, '0, '0,
                                                 acnt_in, '0);
               n = n + 2'd1;
            end else begin
               err_v = 1'b1;
               if (nest_in != pbpa_pkg::NEST_TOP) err_c = pbpa_pkg::ERR_ANNOT;
               else if (phase_in == pbpa_pkg::PH_TAG) err_c = pbpa_pkg::ERR_TAG;
               else if (phase_in == pbpa_pkg::PH_ALEN) err_c = pbpa_pkg::ERR_ALEN;
               else err_c = pbpa_pkg::ERR_SKIP;
            end
         end
         if (err_v) begin
            emit.slot[n] = pbpa_pkg::make_rsp(pbpa_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                                              err_c);
            n = n + 2'd1;
            failed_in = 1'b1;
         end
         if (n != 2'd0) emit.slot[n - 2'd1].run_last = 1'b1;
      end

      // The final byte always leaves the parser ready for a fresh message.
      if (req.last_byte) begin
         phase_in = pbpa_pkg::PH_TAG; nest_in = pbpa_pkg::NEST_TOP;
         accum_in = '0; shift_in = '0; fixed_in = '0;
         al_in = '0; pl_in = '0; sl_in = '0; px_in = '0; py_in = '0;
         topo_in = '0; thick_in = default_thickness;
         pcnt_in = '0; acnt_in = '0; failed_in = 1'b0;
      end
      emit.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pbpa_pkg::PH_TAG; nest_ff <= pbpa_pkg::NEST_TOP;
         accum_ff <= '0; shift_ff <= '0; fixed_ff <= '0;
         al_ff <= '0; pl_ff <= '0; sl_ff <= '0; px_ff <= '0; py_ff <= '0;
         topo_ff <= '0; thick_ff <= pbpa_pkg::DEFAULT_THICKNESS_RESET;
         pcnt_ff <= '0; acnt_ff <= '0; failed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in; nest_ff <= nest_in;
         accum_ff <= accum_in; shift_ff <= shift_in; fixed_ff <= fixed_in;
         al_ff <= al_in; pl_ff <= pl_in; sl_ff <= sl_in; px_ff <= px_in; py_ff <= py_in;
         topo_ff <= topo_in; thick_ff <= thick_in;
         pcnt_ff <= pcnt_in; acnt_ff <= acnt_in; failed_ff <= failed_in;
      end
   end

endmodule

// ----- design/pbpa_fifo.sv -----
// Result queue taking up to three events per cycle and giving one per cycle unless stalled.
module pbpa_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pbpa_pkg::emit_type emit,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pbpa_pkg::rsp_type  rsp_data
);

   pbpa_pkg::rsp_type entry_ff [pbpa_pkg::RSP_DEPTH];
   logic [pbpa_pkg::PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [pbpa_pkg::PTR_BITS:0]   cnt_ff, cnt_in;
   logic [1:0] n;
   logic       pop;

   assign n = push ? emit.count : 2'd0;
   assign pop = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data = entry_ff[rd_ff];
   // Room for the largest burst one request can cause.
   assign full = (cnt_ff > (pbpa_pkg::PTR_BITS + 1)'(pbpa_pkg::RSP_DEPTH - 3));
   assign wr_in = wr_ff + pbpa_pkg::PTR_BITS'(n);
   assign rd_in = rd_ff + pbpa_pkg::PTR_BITS'(pop);
   assign cnt_in = cnt_ff + (pbpa_pkg::PTR_BITS + 1)'(n) - (pbpa_pkg::PTR_BITS + 1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < n) entry_ff[wr_ff + pbpa_pkg::PTR_BITS'(i)] <= emit.slot[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- design/protobuf_points_annotation_parser.sv -----
// Top level: one message byte per request in, point/annotation/done/error events out.
// Each event is registered in the result queue when its request is accepted, and shown in order.
// Throughput: one request per cycle while the result side keeps up; a request that
// causes two or three events gives them out on the result port one at a time, and the
// four-entry result queue stalls requests once fewer than three entries are free.
// Reset (synchronous) clears the parser, the queue and sets thickness to 2.0.
module protobuf_points_annotation_parser #(
   parameter int LENGTH_BITS = pbpa_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbpa_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   logic [63:0] thick_cfg_ff;
   logic        accept, full;
   pbpa_pkg::emit_type emit;

   assign pready = 1'b1;
   assign req_stall = full;
   assign accept = req_valid && !full;
   assign prdata = (paddr[3] == pbpa_pkg::CSR_DEFAULT_THICKNESS) ? thick_cfg_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_cfg_ff <= pbpa_pkg::DEFAULT_THICKNESS_RESET;
      end else if (psel && penable && pwrite && pready
                   && paddr[3] == pbpa_pkg::CSR_DEFAULT_THICKNESS) begin
         thick_cfg_ff <= pwdata;
      end
   end

   pbpa_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
      .clock(clock), .reset(reset), .accept(accept), .req(req_data),
      .default_thickness(thick_cfg_ff), .emit(emit)
   );

   pbpa_fifo u_fifo (
      .clock(clock), .reset(reset), .push(accept), .emit(emit), .full(full),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

// ----- design/pbpa_checker.sv -----
// Port-level checks for the parser and their binding to the top level.
module pbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pbpa_pkg::rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == pbpa_pkg::KIND_DONE |-> rsp_data.run_last)
      else $error("message-done event is not the last of its request");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == pbpa_pkg::KIND_ERROR |-> rsp_data.run_last)
      else $error("error event is not the last of its request");

endmodule

bind protobuf_points_annotation_parser pbpa_checker u_pbpa_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

// ----- dv/protobuf_points_annotation_parser_tb.sv -----
// Testbench for the points-annotation parser: directed and random message traffic checked against a predictor.
`timescale 1ns / 1ps

module protobuf_points_annotation_parser_tb;

   typedef logic [7:0] octet_q_type[$];

   localparam logic [63:0] LEN_LIMIT = (64'd1 << pbpa_pkg::LENGTH_BITS_DEFAULT) - 64'd1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pbpa_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pbpa_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [3:0]        paddr = '0;
   logic [63:0]       pwdata = '0;
   logic [63:0]       prdata;
   logic              pready;

   protobuf_points_annotation_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pbpa_pkg::req_type  pending_bytes[$];
   pbpa_pkg::rsp_type  expected_events[$];
   int       errors = 0;
   int       bytes_sent = 0;
   int       events_seen = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       hold_cycles = 0;
   bit       hold_start = 1'b0;
   logic     req_fire = 1'b0;

   // Predictor state, mirrors the parser's registers.
   logic [63:0] dflt_thick;
   pbpa_pkg::phase_type phase;
   logic [1:0]  nest;
   logic [63:0] accum, ann_left, pt_left, skip_left, pt_x, pt_y, thick;
   int unsigned vshift, fixed_left;
   logic [1:0]  topo;
   logic [15:0] pt_count, ann_count;
   bit          failed;

   function automatic void fresh_message();
      phase = pbpa_pkg::PH_TAG; nest = pbpa_pkg::NEST_TOP; accum = '0; vshift = 0;
      fixed_left = 0;
      ann_left = '0; pt_left = '0; skip_left = '0; pt_x = '0; pt_y = '0;
      topo = 2'd0; thick = dflt_thick; pt_count = '0; ann_count = '0; failed = 1'b0;
   endfunction

   function automatic int ctx_code();
      if (nest != pbpa_pkg::NEST_TOP) return int'(pbpa_pkg::ERR_ANNOT);
      if (phase == pbpa_pkg::PH_TAG) return int'(pbpa_pkg::ERR_TAG);
      if (phase == pbpa_pkg::PH_ALEN) return int'(pbpa_pkg::ERR_ALEN);
      return int'(pbpa_pkg::ERR_SKIP);
   endfunction

   // Returns 1 when the varint completes, 0 if more bytes follow, -1 if too long.
   function automatic int varint_step(logic [7:0] b, output logic [63:0] v);
      v = '0;
      if (vshift < 9) accum |= 64'(b[6:0]) << (7 * vshift);
      else accum |= {b[0], 63'd0};
      if (!b[7]) begin
         v = accum; accum = '0; vshift = 0;
         return 1;
      end
      if (vshift >= 9) return -1;
      vshift++;
      return 0;
   endfunction

   function automatic int begin_skip(logic [2:0] wk);
      case (wk)
         pbpa_pkg::WIRE_VARINT: phase = pbpa_pkg::PH_SKIPV;
         pbpa_pkg::WIRE_FIX64: begin phase = pbpa_pkg::PH_FSKIP; fixed_left = 8; end
         pbpa_pkg::WIRE_LEN: phase = pbpa_pkg::PH_SLEN;
         pbpa_pkg::WIRE_FIX32: begin phase = pbpa_pkg::PH_FSKIP; fixed_left = 4; end
         default: return (nest != pbpa_pkg::NEST_TOP) ? int'(pbpa_pkg::ERR_ANNOT)
                                                      : int'(pbpa_pkg::ERR_SKIP);
      endcase
      return -1;
   endfunction

   function automatic int take_tag(logic [63:0] tag);
      logic [63:0] f;
      logic [2:0]  wk;
      f = tag >> 3;
      wk = tag[2:0];
      if (nest == pbpa_pkg::NEST_TOP) begin
         if (f == 2 && wk == pbpa_pkg::WIRE_LEN) begin
            phase = pbpa_pkg::PH_ALEN; return -1;
         end
      end else if (nest == pbpa_pkg::NEST_ANNOT) begin
         if (f == 2 && wk == pbpa_pkg::WIRE_VARINT) begin
            phase = pbpa_pkg::PH_TOPO; return -1;
         end
         if (f == 3 && wk == pbpa_pkg::WIRE_LEN) begin
            phase = pbpa_pkg::PH_PLEN; return -1;
         end
         if (f == 7 && wk == pbpa_pkg::WIRE_FIX64) begin
            phase = pbpa_pkg::PH_FTHICK; fixed_left = 8; return -1;
         end
      end else begin
         if (f == 1 && wk == pbpa_pkg::WIRE_FIX64) begin
            phase = pbpa_pkg::PH_FX; fixed_left = 8; return -1;
         end
         if (f == 2 && wk == pbpa_pkg::WIRE_FIX64) begin
            phase = pbpa_pkg::PH_FY; fixed_left = 8; return -1;
         end
      end
      return begin_skip(wk);
   endfunction

   function automatic int parse_octet(logic [7:0] b);
      logic [63:0] v;
      int r;
      case (phase)
         pbpa_pkg::PH_TAG, pbpa_pkg::PH_ALEN, pbpa_pkg::PH_PLEN, pbpa_pkg::PH_TOPO,
         pbpa_pkg::PH_SKIPV, pbpa_pkg::PH_SLEN: begin
            r = varint_step(b, v);
            if (r < 0) return ctx_code();
            if (r == 0) return -1;
            case (phase)
               pbpa_pkg::PH_TAG: return take_tag(v);
               pbpa_pkg::PH_ALEN: begin
                  if (v > LEN_LIMIT) return int'(pbpa_pkg::ERR_ANNOT);
                  nest = pbpa_pkg::NEST_ANNOT; ann_left = v; phase = pbpa_pkg::PH_TAG;
                  topo = 2'd0; thick = dflt_thick; pt_count = '0;
               end
               pbpa_pkg::PH_PLEN: begin
                  if (v > LEN_LIMIT || v > ann_left) return int'(pbpa_pkg::ERR_ANNOT);
                  nest = pbpa_pkg::NEST_POINT; pt_left = v; phase = pbpa_pkg::PH_TAG;
                  pt_x = '0; pt_y = '0;
               end
               pbpa_pkg::PH_TOPO: begin
                  topo = (v == 2) ? 2'd1 : (v == 3) ? 2'd2 : (v == 4) ? 2'd3 : 2'd0;
                  phase = pbpa_pkg::PH_TAG;
               end
               pbpa_pkg::PH_SKIPV: phase = pbpa_pkg::PH_TAG;
               default: begin
                  if (v > LEN_LIMIT)
                     return (nest != pbpa_pkg::NEST_TOP) ? int'(pbpa_pkg::ERR_ANNOT)
                                                         : int'(pbpa_pkg::ERR_SKIP);
                  if (nest != pbpa_pkg::NEST_TOP &&
                      v > ((nest == pbpa_pkg::NEST_POINT) ? pt_left : ann_left))
                     return int'(pbpa_pkg::ERR_ANNOT);
                  if (v == 0) phase = pbpa_pkg::PH_TAG;
                  else begin skip_left = v; phase = pbpa_pkg::PH_SBODY; end
               end
            endcase
            return -1;
         end
         pbpa_pkg::PH_SBODY: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = pbpa_pkg::PH_TAG;
            return -1;
         end
         default: begin
            if (fixed_left == 0 || fixed_left > 8) fixed_left = 1;
            accum |= 64'(b) << (8 * (8 - fixed_left));
            fixed_left--;
            if (fixed_left == 0) begin
               if (phase == pbpa_pkg::PH_FX) pt_x = accum;
               else if (phase == pbpa_pkg::PH_FY) pt_y = accum;
               else if (phase == pbpa_pkg::PH_FTHICK) thick = accum;
               accum = '0;
               phase = pbpa_pkg::PH_TAG;
            end
            return -1;
         end
      endcase
   endfunction

   function automatic void predict_events(pbpa_pkg::req_type rq);
      pbpa_pkg::rsp_type evs[$];
      int err;
      bit at_boundary;
      if (failed) begin
         if (rq.last_byte) fresh_message();
         return;
      end
      if (nest != pbpa_pkg::NEST_TOP && ann_left > 0) ann_left--;
      if (nest == pbpa_pkg::NEST_POINT && pt_left > 0) pt_left--;
      err = parse_octet(rq.data_byte);
      if (err < 0) begin
         at_boundary = (phase == pbpa_pkg::PH_TAG && vshift == 0);
         if (nest == pbpa_pkg::NEST_POINT && pt_left == 0) begin
            if (!at_boundary) err = int'(pbpa_pkg::ERR_ANNOT);
            else begin
               evs.insert(evs.size(), pbpa_pkg::make_rsp(pbpa_pkg::KIND_POINT, pt_x, pt_y,
                                                         2'd0, '0, '0, 2'd0));
               if (pt_count != 16'hFFFF) pt_count++;
               nest = pbpa_pkg::NEST_ANNOT;
            end
         end
         if (err < 0 && nest == pbpa_pkg::NEST_ANNOT && ann_left == 0) begin
            if (!at_boundary) err = int'(pbpa_pkg::ERR_ANNOT);
            else begin
               evs.insert(evs.size(), pbpa_pkg::make_rsp(pbpa_pkg::KIND_ANNOT, '0, '0, topo,
                                                         thick, pt_count, 2'd0));
               if (ann_count != 16'hFFFF) ann_count++;
               nest = pbpa_pkg::NEST_TOP;
            end
         end
      end
      if (err < 0 && rq.last_byte) begin
         if (nest == pbpa_pkg::NEST_TOP && phase == pbpa_pkg::PH_TAG && vshift == 0)
            evs.insert(evs.size(), pbpa_pkg::make_rsp(pbpa_pkg::KIND_DONE, '0, '0, 2'd0,
                                                      '0, ann_count, 2'd0));
         else
            err = ctx_code();
      end
      if (err >= 0) begin
         evs.insert(evs.size(), pbpa_pkg::make_rsp(pbpa_pkg::KIND_ERROR, '0, '0, 2'd0,
                                                   '0, '0, 2'(err)));
         failed = 1'b1;
      end
      if (rq.last_byte) fresh_message();
      if (evs.size() > 0) evs[evs.size() - 1].run_last = 1'b1;
      foreach (evs[i]) expected_events.insert(expected_events.size(), evs[i]);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h (time %0t)", what, got, want, $time);
      errors++;
   endtask

   // Monitor and predictor, both on the rising edge.
   always @(posedge clock) begin
      pbpa_pkg::rsp_type want;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         bytes_sent++;
         predict_events(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         events_seen++;
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected event, kind", 64'(rsp_data.event_kind), '0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_data.event_kind != want.event_kind)
               report_mismatch("event_kind", 64'(rsp_data.event_kind),
                               64'(want.event_kind));
            if (rsp_data.x_bits != want.x_bits)
               report_mismatch("x_bits", rsp_data.x_bits, want.x_bits);
            if (rsp_data.y_bits != want.y_bits)
               report_mismatch("y_bits", rsp_data.y_bits, want.y_bits);
            if (rsp_data.topology != want.topology)
               report_mismatch("topology", 64'(rsp_data.topology), 64'(want.topology));
            if (rsp_data.thickness_bits != want.thickness_bits)
               report_mismatch("thickness_bits", rsp_data.thickness_bits, want.thickness_bits);
            if (rsp_data.item_count != want.item_count)
               report_mismatch("item_count", 64'(rsp_data.item_count),
                               64'(want.item_count));
            if (rsp_data.error_code != want.error_code)
               report_mismatch("error_code", 64'(rsp_data.error_code),
                               64'(want.error_code));
            if (rsp_data.run_last != want.run_last)
               report_mismatch("run_last", 64'(rsp_data.run_last), 64'(want.run_last));
         end
      end
   end

   // Request driver: holds the current request until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side stall, random, with a single long hold-off in the last phase.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_cycles <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void put_varint(ref octet_q_type q, input logic [63:0] v);
      do begin
         q.insert(q.size(), {(v >> 7) != 0, v[6:0]});
         v = v >> 7;
      end while (v != 0);
   endfunction

   function automatic void put_fix64(ref octet_q_type q, input logic [63:0] v);
      for (int i = 0; i < 8; i++) q.insert(q.size(), v[8 * i +: 8]);
   endfunction

   function automatic void queue_message(octet_q_type m);
      pbpa_pkg::req_type rq;
      foreach (m[i]) begin
         rq.data_byte = m[i];
         rq.last_byte = (i == m.size() - 1);
         pending_bytes.insert(pending_bytes.size(), rq);
      end
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Builds a well-formed message with random content, sometimes damaged.
   function automatic void build_message(ref octet_q_type m);
      octet_q_type ann, pt;
      m.delete();
      if ($urandom_range(3) == 0) begin
         m.insert(m.size(), 8'h08);
         put_varint(m, rand64());
      end
      repeat ($urandom_range(2)) begin
         ann.delete();
         if ($urandom_range(1)) begin
            ann.insert(ann.size(), 8'h10);
            put_varint(ann, 64'($urandom_range(6)));
         end
         repeat ($urandom_range(2)) begin
            pt.delete();
            if ($urandom_range(3) != 0) begin
               pt.insert(pt.size(), 8'h09); put_fix64(pt, rand64());
            end
            if ($urandom_range(3) != 0) begin
               pt.insert(pt.size(), 8'h11); put_fix64(pt, rand64());
            end
            if ($urandom_range(4) == 0) begin
               pt.insert(pt.size(), 8'h25);
               repeat (4) pt.insert(pt.size(), 8'($urandom));
            end
            ann.insert(ann.size(), 8'h1A);
            put_varint(ann, 64'(pt.size()));
            ann = {ann, pt};
         end
         if ($urandom_range(1)) begin
            ann.insert(ann.size(), 8'h39); put_fix64(ann, rand64());
         end
         if ($urandom_range(4) == 0) begin
            ann.insert(ann.size(), 8'h2A); ann.insert(ann.size(), 8'h02);
            ann.insert(ann.size(), 8'($urandom)); ann.insert(ann.size(), 8'($urandom));
         end
         m.insert(m.size(), 8'h12);
         put_varint(m, 64'(ann.size()));
         m = {m, ann};
      end
      if (m.size() == 0) m.insert(m.size(), 8'h08);
      if (m.size() == 1 && m[0] == 8'h08) m.insert(m.size(), 8'($urandom_range(127)));
      case ($urandom_range(9))
         0: m = m[0:$urandom_range(m.size() - 1)];
         1: m[$urandom_range(m.size() - 1)] = 8'($urandom);
         default: ;
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_bytes.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_thickness(logic [63:0] v);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(8 * pbpa_pkg::CSR_DEFAULT_THICKNESS);
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      dflt_thick = v;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic random_phase(int n_bytes);
      octet_q_type m;
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent + pending_bytes.size() < target) begin
         if ($urandom_range(5) == 0) begin
            m.delete();
            repeat ($urandom_range(1, 6)) m.insert(m.size(), 8'($urandom));
            queue_message(m);
         end else begin
            build_message(m);
            queue_message(m);
         end
         while (pending_bytes.size() > 20) @(posedge clock);
      end
      wait_idle();
   endtask

   initial begin
      dflt_thick = pbpa_pkg::DEFAULT_THICKNESS_RESET;
      fresh_message();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: bad wire kind at the top, empty annotation, full annotation with a
      // zero-length point, overlong varint, buffer ending before an annotation length,
      // and a point longer than its annotation.
      queue_message('{8'h0B});
      queue_message('{8'h12, 8'h00});
      queue_message('{8'h12, 8'h0D, 8'h10, 8'h04, 8'h1A, 8'h00, 8'h39,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      queue_message('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                      8'h80, 8'h80, 8'hFF, 8'h00});
      queue_message('{8'h12});
      queue_message('{8'h12, 8'h02, 8'h1A, 8'h05, 8'h00});
      wait_idle();

      write_thickness('1);
      send_idle_pct = 16; stall_pct = 73;
      random_phase(45);

      write_thickness('0);
      send_idle_pct = 73; stall_pct = 16;
      random_phase(45);

      write_thickness({$urandom, $urandom});
      send_idle_pct = 0; stall_pct = 0;
      @(negedge clock);
      hold_start = 1'b1;
      random_phase(45);

      $display("Covered %0d request bytes and %0d events over three thickness settings,",
               bytes_sent, events_seen);
      $display("with both sides idling, then a long result hold-off, then full rate.");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d events still expected.", expected_events.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
design/pbpa_pkg.sv
design/pbpa_core.sv
design/pbpa_fifo.sv
design/protobuf_points_annotation_parser.sv
design/pbpa_checker.sv
dv/protobuf_points_annotation_parser_tb.sv
